@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define APRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define APRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/aprb_pkg.sv @@
// Package with widths, codes and types of the APNG region pixel blender.
package aprb_pkg;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int EDGE_W     = 14;
  localparam int MUL_W      = 16;
  localparam int NUM_W      = 24;
  localparam int QUO_W      = 8;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BPS;
  localparam int NUM_CH     = 3;

  localparam int CANVAS_DIM_DEF = 4096;
  localparam int DIM_W          = 17;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  localparam logic [CFG_ADDR_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd4;

  typedef enum logic [1:0] {
    MODE_SOURCE = 2'd0,
    MODE_OVER   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  // What the output stage selects for an item.
  typedef enum logic [1:0] {
    KIND_DST   = 2'd0,
    KIND_SRC   = 2'd1,
    KIND_ZERO  = 2'd2,
    KIND_BLEND = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              in_rect;
    logic [PIX_W-1:0]  dst;
    logic [PIX_W-1:0]  src;
    logic [CH_W-1:0]   alpha;
  } side_t;

endpackage

@@ rtl/aprb_div.sv @@
// Pipelined restoring divider giving an 8-bit quotient, two bits per stage.
module aprb_div
  import aprb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [MUL_W-1:0]  den,
  output logic [QUO_W-1:0]  quo
);

  logic [NUM_W-1:0] rem_q [DIV_STAGES];
  logic [MUL_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] rem_out;
    logic [MUL_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] quo_out;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // The quotient never exceeds 255, so the shifted divisor always fits.
    always_comb begin
      rem_out = rem_in;
      quo_out = quo_in;
      for (int j = 0; j < DIV_BPS; j++) begin
        if (rem_out >= (NUM_W'(den_in) << (QUO_W - 1 - k * DIV_BPS - j))) begin
          rem_out = rem_out - (NUM_W'(den_in) << (QUO_W - 1 - k * DIV_BPS - j));
          quo_out[QUO_W - 1 - k * DIV_BPS - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_out;
        den_q[k] <= den_in;
        quo_q[k] <= quo_out;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

@@ rtl/apng_region_pixel_blend.sv @@
// An accepted input item passes the stage 1 and stage 2 registers, the divider stages and the output register.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits on the output.
// Depth is set by the per-channel divider, two quotient bits in each of four stages.
// Reset clears all valid bits and the configuration registers to zero.
`include "assert_macros.svh"

module apng_region_pixel_blend
  import aprb_pkg::*;
#(
  parameter int unsigned CANVAS_DIM = CANVAS_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x[11:0], pos_y[23:12], canvas_pixel[55:24], frame_pixel[87:56]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_pixel[31:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // in_region[0]
  output logic                   m_axis_tuser
);

  localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(CANVAS_DIM);

  logic [COORD_W-1:0] region_left;
  logic [COORD_W-1:0] region_top;
  logic [SIZE_W-1:0]  region_width;
  logic [SIZE_W-1:0]  region_height;
  mode_t              blend_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_left   <= '0;
      region_top    <= '0;
      region_width  <= '0;
      region_height <= '0;
      blend_mode    <= MODE_SOURCE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LEFT:   region_left   <= cfg_wdata[COORD_W-1:0];
        REG_TOP:    region_top    <= cfg_wdata[COORD_W-1:0];
        REG_WIDTH:  region_width  <= cfg_wdata;
        REG_HEIGHT: region_height <= cfg_wdata;
        REG_MODE:   blend_mode    <= mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: region test, mode decision and the alpha weights.
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [PIX_W-1:0]   canvas_pixel;
  logic [PIX_W-1:0]   frame_pixel;
  logic [CH_W-1:0]    a_src;
  logic [CH_W-1:0]    a_dst;
  logic               on_canvas;
  logic               in_rect;
  kind_t              kind;
  logic [EDGE_W-1:0]  right_edge;
  logic [EDGE_W-1:0]  bottom_edge;

  assign pos_x        = s_axis_tdata[11:0];
  assign pos_y        = s_axis_tdata[23:12];
  assign canvas_pixel = s_axis_tdata[55:24];
  assign frame_pixel  = s_axis_tdata[87:56];
  assign a_src        = frame_pixel[PIX_W-1 -: CH_W];
  assign a_dst        = canvas_pixel[PIX_W-1 -: CH_W];

  always_comb begin
    right_edge  = EDGE_W'(region_left) + EDGE_W'(region_width);
    bottom_edge = EDGE_W'(region_top) + EDGE_W'(region_height);
    on_canvas   = (DIM_W'(pos_x) < DIM_LIM) && (DIM_W'(pos_y) < DIM_LIM);
    in_rect     = on_canvas && (pos_x >= region_left) && (EDGE_W'(pos_x) < right_edge) &&
                  (pos_y >= region_top) && (EDGE_W'(pos_y) < bottom_edge);
    kind = KIND_DST;
    if (in_rect) begin
      unique case (blend_mode)
        MODE_SOURCE: kind = KIND_SRC;
        MODE_CLEAR:  kind = KIND_ZERO;
        MODE_OVER: begin
          if (a_src == '0)                          kind = KIND_DST;
          else if (a_src == CH_MAX || a_dst == '0)  kind = KIND_SRC;
          else                                      kind = KIND_BLEND;
        end
        default: kind = KIND_DST;
      endcase
    end
  end

  logic             vld1;
  side_t            side1;
  logic [MUL_W-1:0] u1;
  logic [MUL_W-1:0] v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv) begin
      vld1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1.kind    <= kind;
      side1.in_rect <= in_rect;
      side1.dst     <= canvas_pixel;
      side1.src     <= frame_pixel;
      side1.alpha   <= '0;
      u1            <= {a_src, 8'd0} - MUL_W'(a_src);
      v1            <= MUL_W'(CH_MAX - a_src) * MUL_W'(a_dst);
    end
  end

  // Stage 2: total weight, result alpha and the three channel numerators.
  logic [MUL_W-1:0] s_sum;
  logic [DIM_W-1:0] s_div_tmp;
  logic [NUM_W-1:0] num [NUM_CH];
  side_t            side_s2;

  always_comb begin
    s_sum     = u1 + v1;
    // Exact floor division by 255 for any sum below 65535, which covers every sum here.
    s_div_tmp = DIM_W'(s_sum) + DIM_W'(s_sum >> 8) + DIM_W'(1);
    side_s2       = side1;
    side_s2.alpha = s_div_tmp[15:8];
    for (int c = 0; c < NUM_CH; c++) begin
      num[c] = NUM_W'(side1.src[c*CH_W +: CH_W]) * NUM_W'(u1) +
               NUM_W'(side1.dst[c*CH_W +: CH_W]) * NUM_W'(v1);
    end
  end

  logic             vld2;
  side_t            side2;
  logic [NUM_W-1:0] num2 [NUM_CH];
  logic [MUL_W-1:0] den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2 <= side_s2;
      num2  <= num;
      den2  <= s_sum;
    end
  end

  // Divider stages, one divider per color channel.
  logic [QUO_W-1:0] quo [NUM_CH];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    aprb_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num2[c]),
      .den (den2),
      .quo (quo[c])
    );
  end

  logic  vld_d  [DIV_STAGES];
  side_t side_d [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) vld_d[i] <= 1'b0;
    end else if (adv) begin
      vld_d[0] <= vld2;
      for (int i = 1; i < DIV_STAGES; i++) vld_d[i] <= vld_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= side2;
      for (int i = 1; i < DIV_STAGES; i++) side_d[i] <= side_d[i-1];
    end
  end

  // Output stage.
  side_t            side_l;
  logic [PIX_W-1:0] result_pixel;

  assign side_l = side_d[DIV_STAGES-1];

  always_comb begin
    unique case (side_l.kind)
      KIND_DST:   result_pixel = side_l.dst;
      KIND_SRC:   result_pixel = side_l.src;
      KIND_ZERO:  result_pixel = '0;
      KIND_BLEND: result_pixel = {side_l.alpha, quo[2], quo[1], quo[0]};
      default:    result_pixel = side_l.dst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= vld_d[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= result_pixel;
      m_axis_tuser <= side_l.in_rect;
    end
  end

  logic last_go;
  logic last_zero;
  assign last_go   = adv && vld_d[DIV_STAGES-1];
  assign last_zero = last_go && (side_l.kind == KIND_ZERO);

  `APRB_ASSERT_NOW(a_outside_keeps_canvas, vld1 && !side1.in_rect, side1.kind == KIND_DST)
  `APRB_ASSERT_NEXT(a_last_stage_delivers, last_go, m_axis_tvalid)
  `APRB_ASSERT_NEXT(a_clear_gives_zero, last_zero, m_axis_tdata == '0 && m_axis_tuser)
  `APRB_ASSERT_NEXT(a_outside_passes, last_go && !side_l.in_rect, m_axis_tdata == $past(side_l.dst))

endmodule

@@ tb/apng_region_pixel_blend_test.sv @@
// Self-checking testbench for the APNG region pixel blender: directed and random pixels.
module apng_region_pixel_blend_test;
  import aprb_pkg::*;

  localparam int LATENCY = 7;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0]   frame;
    logic [PIX_W-1:0]   canvas;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_x;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             in_region;
  } blend_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // Local copy of the block's registers.
  logic [COORD_W-1:0] reg_left = '0;
  logic [COORD_W-1:0] reg_top = '0;
  logic [SIZE_W-1:0]  reg_width = '0;
  logic [SIZE_W-1:0]  reg_height = '0;
  logic [1:0]         reg_mode = MODE_SOURCE;

  pixel_item_t   pending_pixels[$];
  blend_result_t expected_pixels[$];
  pixel_item_t   drv_item;
  blend_result_t exp_pixel;
  int            queued_count = 0;
  int            accepted_count = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            mismatch_count = 0;
  bit            quiet = 1'b0;

  apng_region_pixel_blend dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Straight-alpha source-over of one frame pixel onto one canvas pixel.
  function automatic logic [PIX_W-1:0] over_blend(input logic [PIX_W-1:0] dst,
                                                  input logic [PIX_W-1:0] src);
    int unsigned a, d, u, v, s, c;
    logic [PIX_W-1:0] r;
    a = src[31:24];
    d = dst[31:24];
    if (a == 0) return dst;
    if (a == 255 || d == 0) return src;
    u = a * 255;
    v = (255 - a) * d;
    s = u + v;
    r = '0;
    c = s / 255;
    r[31:24] = c[7:0];
    for (int k = 0; k < NUM_CH; k++) begin
      c = (int'(src[8*k +: 8]) * u + int'(dst[8*k +: 8]) * v) / s;
      r[8*k +: 8] = c[7:0];
    end
    return r;
  endfunction

  function automatic blend_result_t composite_pixel(input pixel_item_t it);
    blend_result_t r;
    int unsigned x, y;
    bit hit;
    x = it.pos_x;
    y = it.pos_y;
    hit = x < CANVAS_DIM_DEF && y < CANVAS_DIM_DEF &&
          x >= reg_left && x < int'(reg_left) + int'(reg_width) &&
          y >= reg_top && y < int'(reg_top) + int'(reg_height);
    r.pixel = it.canvas;
    r.in_region = hit;
    if (hit) begin
      case (reg_mode)
        MODE_SOURCE: r.pixel = it.frame;
        MODE_OVER:   r.pixel = over_blend(it.canvas, it.frame);
        MODE_CLEAR:  r.pixel = '0;
        default:     r.pixel = it.canvas;
      endcase
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      default: ;
    endcase
    return p;
  endfunction

  task automatic queue_pixel(input int unsigned x, input int unsigned y,
                             input logic [PIX_W-1:0] canvas, input logic [PIX_W-1:0] frame);
    pixel_item_t it;
    it.pos_x = x[COORD_W-1:0];
    it.pos_y = y[COORD_W-1:0];
    it.canvas = canvas;
    it.frame = frame;
    pending_pixels.push_back(it);
    queued_count++;
  endtask

  // Most pixels fall on or just around the rectangle, the rest anywhere.
  task automatic queue_random_pixel();
    int unsigned lo_x, hi_x, lo_y, hi_y;
    lo_x = (reg_left > 2) ? reg_left - 2 : 0;
    hi_x = int'(reg_left) + int'(reg_width) + 1;
    if (hi_x > 4095) hi_x = 4095;
    lo_y = (reg_top > 2) ? reg_top - 2 : 0;
    hi_y = int'(reg_top) + int'(reg_height) + 1;
    if (hi_y > 4095) hi_y = 4095;
    if ($urandom_range(0, 9) < 7)
      queue_pixel($urandom_range(lo_x, hi_x), $urandom_range(lo_y, hi_y),
                  random_pixel(), random_pixel());
    else
      queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                  random_pixel(), random_pixel());
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_LEFT:   reg_left = data[COORD_W-1:0];
      REG_TOP:    reg_top = data[COORD_W-1:0];
      REG_WIDTH:  reg_width = data;
      REG_HEIGHT: reg_height = data;
      REG_MODE:   reg_mode = data[1:0];
      default: ;
    endcase
  endtask

  task automatic set_region(input logic [CFG_DATA_W-1:0] left, input logic [CFG_DATA_W-1:0] top,
                            input logic [CFG_DATA_W-1:0] width,
                            input logic [CFG_DATA_W-1:0] height,
                            input logic [CFG_DATA_W-1:0] mode);
    cfg_write(REG_LEFT, left);
    cfg_write(REG_TOP, top);
    cfg_write(REG_WIDTH, width);
    cfg_write(REG_HEIGHT, height);
    cfg_write(REG_MODE, mode);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every queued item has come out of the block.
  task automatic drain();
    while (accepted_count != queued_count || expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_offset();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 13'(4095 - $urandom_range(0, 20));
      2: return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_size();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 13'd4096;
      2: return 13'd8191;
      3: return 13'($urandom_range(1, 4));
      default: return 13'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_mode();
    case ($urandom_range(0, 5))
      0: return 13'(MODE_SOURCE);
      4: return 13'(MODE_CLEAR);
      5: return {11'($urandom_range(0, 2047)), MODE_UNUSED};
      default: return 13'(MODE_OVER);
    endcase
  endfunction

  // Sender: holds an item until it is taken and predicts it at acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(composite_pixel(drv_item));
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
          s_axis_tvalid <= 1'b0;
        end else begin
          drv_item = pending_pixels.pop_front();
          s_axis_tdata <= drv_item;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // Receiver stalls in short bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no item pending: result_pixel %08h in_region %0b",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        exp_pixel = expected_pixels.pop_front();
        if (m_axis_tdata !== exp_pixel.pixel) begin
          $error("result_pixel: expected %08h, got %08h", exp_pixel.pixel, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== exp_pixel.in_region) begin
          $error("in_region: expected %0b, got %0b", exp_pixel.in_region, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: the rectangle is empty.
    queue_pixel(0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_pixel(4095, 4095, 32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    // Whole canvas in copy mode.
    set_region(0, 0, 4096, 4096, 13'(MODE_SOURCE));
    queue_pixel(0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_pixel(4095, 4095, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    // Corner pixel with the right edge far beyond the canvas, over mode.
    set_region(4095, 4095, 4096, 1, 13'(MODE_OVER));
    queue_pixel(4095, 4095, 32'h80C0_4020, 32'h0011_2233);
    queue_pixel(4095, 4095, 32'h80C0_4020, 32'hFF11_2233);
    queue_pixel(4095, 4095, 32'h00C0_4020, 32'h4011_2233);
    queue_pixel(4095, 4095, 32'h80FF_00FF, 32'h7F00_FF00);
    queue_pixel(4094, 4095, 32'h80C0_4020, 32'hFF11_2233);
    drain();

    // Small rectangle cleared; probe each edge from both sides.
    set_region(10, 20, 5, 3, 13'(MODE_CLEAR));
    queue_pixel(10, 20, 32'hDEAD_BEEF, 32'h1234_5678);
    queue_pixel(14, 22, 32'hDEAD_BEEF, 32'h1234_5678);
    queue_pixel(15, 22, 32'hDEAD_BEEF, 32'h1234_5678);
    queue_pixel(9, 20, 32'hDEAD_BEEF, 32'h1234_5678);
    queue_pixel(10, 23, 32'hDEAD_BEEF, 32'h1234_5678);
    queue_pixel(10, 19, 32'hDEAD_BEEF, 32'h1234_5678);
    drain();

    // Unused mode and register values wider than their fields.
    set_region(13'h1005, 13'h1005, 8191, 8191, 13'h1FFF);
    queue_pixel(5, 5, 32'hCAFE_F00D, 32'h0BAD_CAFE);
    queue_pixel(4, 5, 32'hCAFE_F00D, 32'h0BAD_CAFE);
    drain();

    // Zero width, then zero height.
    set_region(0, 0, 0, 100, 13'(MODE_SOURCE));
    queue_pixel(0, 0, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    set_region(0, 0, 100, 0, 13'(MODE_SOURCE));
    queue_pixel(0, 0, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 9) quiet = 1'b1;
      if (phase == 0) begin
        // A write to an unmapped index must change nothing.
        cfg_write(REG_NONE, 13'($urandom_range(0, 8191)));
      end
      set_region(random_offset(), random_offset(), random_size(), random_size(),
                 random_mode());
      for (int n = 0; n < 50; n++) queue_random_pixel();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/aprb_pkg.sv
rtl/aprb_div.sv
rtl/apng_region_pixel_blend.sv
tb/apng_region_pixel_blend_test.sv
